// ===== src/slir_pkg.sv =====
// ----------------------------------------------------------------------------
// slir_pkg
// Shared types and constants for the sorted list increase-and-reposition block.
// ----------------------------------------------------------------------------
package slir_pkg;

    // Default list capacity
    localparam int SLIR_DEPTH = 16;

    // Field widths
    localparam int SLIR_VAL_W = 32;
    localparam int SLIR_POS_W = 6;
    localparam int SLIR_REQ_W = 2;

    // Request codes
    localparam logic [SLIR_REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [SLIR_REQ_W-1:0] REQ_ADJUST = 2'd1;
    localparam logic [SLIR_REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_EMIT_RD,
        S_EMIT_LD,
        S_OUT
    } t_state;

endpackage

// ===== src/slir_ram.sv =====
// ----------------------------------------------------------------------------
// slir_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module slir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sorted_list_increase_reposition.sv =====
// ----------------------------------------------------------------------------
// sorted_list_increase_reposition
// Ascending list of signed 32-bit values with append, clear and adjust.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one request per transaction.
//   Output channel (o_valid / i_stall) carries result transactions.
//   Append: one result, shown the cycle after acceptance (overflow if full).
//   Clear: no result, the block is ready again in the next cycle.
//   Adjust: the entry is read, summed with the amount, then moved toward the
//   tail one entry per cycle through the single RAM port pair; afterwards the
//   whole list is emitted, each result through a registered RAM read and the
//   output register handshake. A bad position leaves the list unchanged and
//   sets bad_position on every emitted result.
//   An empty list gives one result with list_empty set.
//   o_stall is high while a request is in progress; one request at a time.
//   A stalled result holds in the output register until taken.
//   Reset clears the entry count and returns to idle; the RAM is not cleared,
//   only entries below the count are ever used.
// ----------------------------------------------------------------------------
module sorted_list_increase_reposition
    import slir_pkg::*;
#(
    parameter int DEPTH = SLIR_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [SLIR_REQ_W-1:0]        i_req_type,
    input  logic signed [SLIR_VAL_W-1:0] i_new_value,
    input  logic [SLIR_POS_W-1:0]        i_position,
    input  logic signed [SLIR_VAL_W-1:0] i_amount,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [SLIR_VAL_W-1:0] o_element,
    output logic [SLIR_POS_W-1:0]        o_element_index,
    output logic                         o_is_last,
    output logic                         o_list_empty,
    output logic                         o_bad_position,
    output logic                         o_overflow
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PCW = (CW > SLIR_POS_W) ? CW : SLIR_POS_W;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_pos, n_pos;
    logic [SLIR_VAL_W-1:0] r_amt, n_amt;
    logic [SLIR_VAL_W-1:0] r_val, n_val;
    logic [CW-1:0]         r_j, n_j;
    logic [AW-1:0]         r_idx, n_idx;
    logic                  r_bad, n_bad;

    logic [SLIR_VAL_W-1:0] r_o_elem, n_o_elem;
    logic [AW-1:0]         r_o_idx, n_o_idx;
    logic                  r_o_last, n_o_last;
    logic                  r_o_empty, n_o_empty;
    logic                  r_o_bad, n_o_bad;
    logic                  r_o_ovf, n_o_ovf;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [SLIR_VAL_W-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [SLIR_VAL_W-1:0] ram_rdata;

    logic                  in_acc;
    logic                  out_acc;
    logic                  list_full;
    logic                  pos_bad;
    logic                  scan_move;

    assign in_acc    = i_valid && (r_state == S_IDLE);
    assign out_acc   = (r_state == S_OUT) && !i_stall;
    assign list_full = (r_count == CW'(DEPTH));
    assign pos_bad   = (PCW'(i_position) >= PCW'(r_count));
    // Shared compare: keep moving while the next entry is strictly smaller
    assign scan_move = (r_j < r_count) && ($signed(ram_rdata) < $signed(r_val));

    slir_ram #(
        .WIDTH(SLIR_VAL_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority if (i_req_type == REQ_APPEND) begin
                        n_state = S_OUT;
                    end else if (i_req_type == REQ_ADJUST) begin
                        priority if (r_count == '0) begin
                            n_state = S_OUT;
                        end else if (pos_bad) begin
                            n_state = S_EMIT_LD;
                        end else begin
                            n_state = S_ADD;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ADD:     n_state = S_SCAN;
            S_SCAN:    n_state = scan_move ? S_SCAN : S_EMIT_RD;
            S_EMIT_RD: n_state = S_EMIT_LD;
            S_EMIT_LD: n_state = S_OUT;
            S_OUT: begin
                if (out_acc) begin
                    n_state = r_o_last ? S_IDLE : S_EMIT_LD;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        n_count   = r_count;
        n_pos     = r_pos;
        n_amt     = r_amt;
        n_val     = r_val;
        n_j       = r_j;
        n_idx     = r_idx;
        n_bad     = r_bad;
        n_o_elem  = r_o_elem;
        n_o_idx   = r_o_idx;
        n_o_last  = r_o_last;
        n_o_empty = r_o_empty;
        n_o_bad   = r_o_bad;
        n_o_ovf   = r_o_ovf;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_val;
        ram_raddr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority if (i_req_type == REQ_APPEND) begin
                        n_o_last  = 1'b1;
                        n_o_empty = 1'b0;
                        n_o_bad   = 1'b0;
                        if (list_full) begin
                            n_o_elem = '0;
                            n_o_idx  = '0;
                            n_o_ovf  = 1'b1;
                        end else begin
                            // Store at the tail and echo the value
                            ram_we    = 1'b1;
                            ram_waddr = AW'(r_count);
                            ram_wdata = i_new_value;
                            n_o_elem  = i_new_value;
                            n_o_idx   = AW'(r_count);
                            n_o_ovf   = 1'b0;
                            n_count   = r_count + CW'(1);
                        end
                    end else if (i_req_type == REQ_ADJUST) begin
                        n_pos = AW'(i_position);
                        n_amt = i_amount;
                        n_bad = pos_bad;
                        n_idx = '0;
                        priority if (r_count == '0) begin
                            n_o_elem  = '0;
                            n_o_idx   = '0;
                            n_o_last  = 1'b1;
                            n_o_empty = 1'b1;
                            n_o_bad   = 1'b0;
                            n_o_ovf   = 1'b0;
                        end else if (pos_bad) begin
                            // List stays as is; start emission at the head
                            ram_raddr = '0;
                        end else begin
                            ram_raddr = AW'(i_position);
                        end
                    end else if (i_req_type == REQ_CLEAR) begin
                        n_count = '0;
                    end else begin
                        n_count = r_count;
                    end
                end
            end
            S_ADD: begin
                // Wrapped sum, then fetch the following entry
                n_val     = ram_rdata + r_amt;
                n_j       = CW'(r_pos) + CW'(1);
                ram_raddr = AW'(CW'(r_pos) + CW'(1));
            end
            S_SCAN: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_j - CW'(1));
                if (scan_move) begin
                    // Shift the smaller entry one place toward the head
                    ram_wdata = ram_rdata;
                    n_j       = r_j + CW'(1);
                    ram_raddr = AW'(r_j + CW'(1));
                end else begin
                    ram_wdata = r_val;
                end
            end
            S_EMIT_RD: begin
                ram_raddr = '0;
            end
            S_EMIT_LD: begin
                n_o_elem  = ram_rdata;
                n_o_idx   = r_idx;
                n_o_last  = ((CW'(r_idx) + CW'(1)) == r_count);
                n_o_empty = 1'b0;
                n_o_bad   = r_bad;
                n_o_ovf   = 1'b0;
            end
            S_OUT: begin
                // Advance to the next entry once the result is taken
                if (out_acc && !r_o_last) begin
                    n_idx     = r_idx + AW'(1);
                    ram_raddr = r_idx + AW'(1);
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_amt     <= n_amt;
        r_val     <= n_val;
        r_j       <= n_j;
        r_idx     <= n_idx;
        r_bad     <= n_bad;
        r_o_elem  <= n_o_elem;
        r_o_idx   <= n_o_idx;
        r_o_last  <= n_o_last;
        r_o_empty <= n_o_empty;
        r_o_bad   <= n_o_bad;
        r_o_ovf   <= n_o_ovf;
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_element       = $signed(r_o_elem);
    assign o_element_index = SLIR_POS_W'(r_o_idx);
    assign o_is_last       = r_o_last;
    assign o_list_empty    = r_o_empty;
    assign o_bad_position  = r_o_bad;
    assign o_overflow      = r_o_ovf;

endmodule

// ===== src/slir_checker.sv =====
// ----------------------------------------------------------------------------
// slir_checker
// Port-level checks for the sorted list increase-and-reposition block.
// ----------------------------------------------------------------------------
module slir_checker
    import slir_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         o_stall,
    input  logic [SLIR_REQ_W-1:0]        i_req_type,
    input  logic signed [SLIR_VAL_W-1:0] i_new_value,
    input  logic [SLIR_POS_W-1:0]        i_position,
    input  logic signed [SLIR_VAL_W-1:0] i_amount,
    input  logic                         o_valid,
    input  logic                         i_stall,
    input  logic signed [SLIR_VAL_W-1:0] o_element,
    input  logic [SLIR_POS_W-1:0]        o_element_index,
    input  logic                         o_is_last,
    input  logic                         o_list_empty,
    input  logic                         o_bad_position,
    input  logic                         o_overflow
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_element) && $stable(o_is_last))
        else $error("stalled result changed");

    // An accepted append shows its result in the next cycle
    a_append_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_req_type == REQ_APPEND) |=> o_valid && o_is_last)
        else $error("append result missing");

    // No request is taken while a result is pending
    a_busy_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input ready while result pending");

    // Empty and overflow results stand alone with a zero element
    a_single_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_list_empty || o_overflow) |->
            o_is_last && (o_element == 0) && (o_element_index == 0) && !o_bad_position)
        else $error("malformed empty or overflow result");

endmodule

bind sorted_list_increase_reposition slir_checker u_slir_checker (.*);
